FILE: design/hfcc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the frame checker.
package hfcc_pkg;

  // CRC-8, polynomial x^8+x^5+x^4+1, MSB first, no final XOR
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Frame layout: temperature word, its CRC, humidity word, its CRC
  localparam logic [2:0] POS_TEMP_HI = 3'd0;
  localparam logic [2:0] POS_TEMP_LO = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI = 3'd3;
  localparam logic [2:0] POS_HUM_LO = 3'd4;
  localparam logic [2:0] POS_HUM_CRC = 3'd5;

  // Conversion scales; both divide by full scale 65535
  localparam logic [14:0] TEMP_SCALE = 15'd17500;
  localparam logic [13:0] HUM_SCALE = 14'd10000;
  localparam logic [15:0] FULL_SCALE = 16'hFFFF;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

  // Limit register reset values
  localparam logic signed [14:0] TEMP_LOW_RESET = -15'sd2000;
  localparam logic signed [14:0] TEMP_HIGH_RESET = 15'sd12500;

  // Register indexes on the APB port
  localparam logic REG_TEMP_LOW = 1'b0;
  localparam logic REG_TEMP_HIGH = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_TEMP_RANGE = 2'd2
  } status_e;

  // One byte through the CRC, one bit per step
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: design/humidity_frame_crc_convert.sv
// Sensor frame byte assembler with CRC-8 check and fixed-point conversion.
//
// Usage: frame bytes enter on the input channel (data_byte_i, frame_start_i),
// one transfer per byte: temperature high, low, CRC, humidity high, low, CRC.
// frame_start_i marks byte zero and drops any partial frame; after a complete
// frame the next byte is byte zero regardless of the flag.
// After the sixth byte one result leaves on the output channel: converted
// temperature and humidity, both raw words and a status (ok, CRC error, or
// temperature outside the limits held in the two APB registers).
// Pipeline: the sixth byte's transfer loads the product stage with the
// constant multiplies; the output register then takes the quotient
// correction and limit compare. Throughput: one byte per cycle while
// input ready is high; a byte's CRC update is done in its transfer cycle.
// A stalled receiver holds the result in the output register; one further
// finished frame can wait in the product stage, and only then is input
// ready dropped.
// Reset clears the frame position, the CRC, both pipeline valids and loads
// the limits with -20.00 and 125.00 degrees.
module humidity_frame_crc_convert
  import hfcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // byte input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_start_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [14:0]  temperature_centi_o,
  output logic [13:0]         humidity_centi_o,
  output logic [15:0]         raw_temperature_o,
  output logic [15:0]         raw_humidity_o,
  output logic [1:0]          status_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // ---------------------------------------------------------------
  // Configuration registers
  logic signed [14:0] temp_low_q, temp_high_q;
  logic               cfg_wr;
  logic               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_low_q  <= TEMP_LOW_RESET;
      temp_high_q <= TEMP_HIGH_RESET;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_TEMP_LOW) begin
        temp_low_q <= pwdata[14:0];
      end else begin
        temp_high_q <= pwdata[14:0];
      end
    end
  end

  // read back sign-extended
  always_comb begin
    if (cfg_idx == REG_TEMP_LOW) begin
      prdata = 32'($signed(temp_low_q));
    end else begin
      prdata = 32'($signed(temp_high_q));
    end
  end

  // ---------------------------------------------------------------
  // Handshakes
  logic in_xfer;
  logic s1_valid_q, out_valid_q;
  logic s1_ready, out_load;

  assign out_load   = ~out_valid_q | out_ready_i;
  assign s1_ready   = ~s1_valid_q | out_load;
  assign in_ready_o = s1_ready;
  assign in_xfer    = in_valid_i & in_ready_o;

  // ---------------------------------------------------------------
  // Frame assembly state
  logic [2:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_d, crc_base;
  logic [15:0] temp_word_q, temp_word_d, temp_word_base;
  logic [15:0] hum_word_q, hum_word_d, hum_word_base;
  logic        crc_fail_q, crc_fail_d, crc_fail_base;
  logic        frame_done;

  always_comb begin
    // start flag or an unused code restarts the frame
    pos = (frame_start_i || pos_q > POS_HUM_CRC) ? POS_TEMP_HI : pos_q;

    if (pos == POS_TEMP_HI) begin
      crc_base       = CRC_INIT;
      crc_fail_base  = 1'b0;
      temp_word_base = '0;
      hum_word_base  = '0;
    end else begin
      crc_base       = crc_q;
      crc_fail_base  = crc_fail_q;
      temp_word_base = temp_word_q;
      hum_word_base  = hum_word_q;
    end

    crc_d       = crc_base;
    crc_fail_d  = crc_fail_base;
    temp_word_d = temp_word_base;
    hum_word_d  = hum_word_base;

    case (pos)
      POS_TEMP_HI, POS_TEMP_LO: begin
        temp_word_d = {temp_word_base[7:0], data_byte_i};
        crc_d       = crc8_byte(crc_base, data_byte_i);
      end
      POS_HUM_HI, POS_HUM_LO: begin
        hum_word_d = {hum_word_base[7:0], data_byte_i};
        crc_d      = crc8_byte(crc_base, data_byte_i);
      end
      default: begin
        // CRC byte: compare and restart the CRC for the next word
        crc_fail_d = crc_fail_base | (crc_base != data_byte_i);
        crc_d      = CRC_INIT;
      end
    endcase

    frame_done = (pos == POS_HUM_CRC);
    pos_d      = frame_done ? POS_TEMP_HI : pos + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_TEMP_HI;
      crc_q       <= CRC_INIT;
      crc_fail_q  <= 1'b0;
      temp_word_q <= '0;
      hum_word_q  <= '0;
    end else if (in_xfer) begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      crc_fail_q  <= crc_fail_d;
      temp_word_q <= temp_word_d;
      hum_word_q  <= hum_word_d;
    end
  end

  // ---------------------------------------------------------------
  // Product stage: constant multiplies on the finished words
  logic [30:0] temp_prod, s1_temp_prod_q;
  logic [29:0] hum_prod, s1_hum_prod_q;
  logic [15:0] s1_raw_temp_q, s1_raw_hum_q;
  logic        s1_crc_fail_q;
  logic        s1_load;

  assign temp_prod = 31'(temp_word_base) * 31'(TEMP_SCALE);
  assign hum_prod  = 30'(hum_word_base) * 30'(HUM_SCALE);
  assign s1_load   = in_xfer & frame_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s1_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_temp_prod_q <= temp_prod;
      s1_hum_prod_q  <= hum_prod;
      s1_raw_temp_q  <= temp_word_base;
      s1_raw_hum_q   <= hum_word_base;
      s1_crc_fail_q  <= crc_fail_d;
    end
  end

  // ---------------------------------------------------------------
  // Divide by 65535: quotient from the top half, one correction step.
  // p = q0*65536 + lo = q0*65535 + (q0 + lo), and q0 + lo < 2*65535.
  logic [14:0]        temp_q0, temp_quot;
  logic [16:0]        temp_rem;
  logic [13:0]        hum_q0, hum_quot;
  logic [16:0]        hum_rem;
  logic signed [15:0] temp_centi, low_ext, high_ext;
  status_e            status_d;

  always_comb begin
    temp_q0   = s1_temp_prod_q[30:16];
    temp_rem  = 17'(s1_temp_prod_q[15:0]) + 17'(temp_q0);
    temp_quot = temp_q0 + 15'(temp_rem >= 17'(FULL_SCALE));

    hum_q0   = s1_hum_prod_q[29:16];
    hum_rem  = 17'(s1_hum_prod_q[15:0]) + 17'(hum_q0);
    hum_quot = hum_q0 + 14'(hum_rem >= 17'(FULL_SCALE));

    temp_centi = $signed({1'b0, temp_quot}) - TEMP_OFFSET;
    low_ext    = 16'(temp_low_q);
    high_ext   = 16'(temp_high_q);

    // CRC error wins over the limit check
    if (s1_crc_fail_q) begin
      status_d = STATUS_CRC_ERR;
    end else if (temp_centi < low_ext || temp_centi > high_ext) begin
      status_d = STATUS_TEMP_RANGE;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // ---------------------------------------------------------------
  // Output register
  logic signed [14:0] temp_out_q;
  logic [13:0]        hum_out_q;
  logic [15:0]        raw_temp_out_q, raw_hum_out_q;
  status_e            status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      temp_out_q     <= temp_centi[14:0];
      hum_out_q      <= hum_quot;
      raw_temp_out_q <= s1_raw_temp_q;
      raw_hum_out_q  <= s1_raw_hum_q;
      status_q       <= status_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign temperature_centi_o = temp_out_q;
  assign humidity_centi_o    = hum_out_q;
  assign raw_temperature_o   = raw_temp_out_q;
  assign raw_humidity_o      = raw_hum_out_q;
  assign status_o            = status_q;

endmodule
